// ===== rtl/wavhp_pkg.sv =====
// Shared types and constants for the WAVE header parser.
package wavhp_pkg;

    localparam int HEADER_BYTES = 256;
    localparam int POS_W        = $clog2(HEADER_BYTES + 1);
    localparam int OFFSET_W     = 9;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_PCM_SIZE = 32'h0000_0010;
    localparam logic [15:0] FMT_TAG_PCM  = 16'h0001;
    localparam logic [15:0] PCM_BITS     = 16'h0010;
    localparam logic [15:0] EXT_NONE     = 16'h0000;

    // Header layout: data tag without extension, extension size plus fact chunk header, chunk header.
    localparam int DATA_TAG_BASE = 36;
    localparam int FACT_HDR      = 10;
    localparam int CHUNK_HDR     = 8;
    localparam int FACT_LEN_MAX  = HEADER_BYTES - DATA_TAG_BASE - FACT_HDR - CHUNK_HDR;

    // Offsets of the last byte of each header field.
    localparam logic [POS_W-1:0] OFS_RIFF_TAG   = POS_W'(3);
    localparam logic [POS_W-1:0] OFS_RIFF_SIZE  = POS_W'(7);
    localparam logic [POS_W-1:0] OFS_WAVE_TAG   = POS_W'(11);
    localparam logic [POS_W-1:0] OFS_FMT_TAG    = POS_W'(15);
    localparam logic [POS_W-1:0] OFS_FMT_SIZE   = POS_W'(19);
    localparam logic [POS_W-1:0] OFS_FMT_CODE   = POS_W'(21);
    localparam logic [POS_W-1:0] OFS_CHANNELS   = POS_W'(23);
    localparam logic [POS_W-1:0] OFS_RATE       = POS_W'(27);
    localparam logic [POS_W-1:0] OFS_BYTE_RATE  = POS_W'(31);
    localparam logic [POS_W-1:0] OFS_ALIGN      = POS_W'(33);
    localparam logic [POS_W-1:0] OFS_BITS       = POS_W'(35);
    localparam logic [POS_W-1:0] OFS_EXT_SIZE   = POS_W'(37);
    localparam logic [POS_W-1:0] OFS_FACT_LEN   = POS_W'(45);

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_NO_RIFF   = 4'd1,
        ST_NO_WAVE   = 4'd2,
        ST_NO_FMT    = 4'd3,
        ST_NOT_PCM   = 4'd4,
        ST_NOT_16BIT = 4'd5,
        ST_EXT_SET   = 4'd6,
        ST_NO_DATA   = 4'd7,
        ST_TRUNC     = 4'd8
    } status_t;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       first_byte;
        logic       last_byte;
    } wav_in_t;

    typedef struct packed {
        status_t             status;
        logic [15:0]         num_channels;
        logic [31:0]         samples_per_sec;
        logic [31:0]         byte_rate;
        logic [15:0]         block_align;
        logic [15:0]         sample_bits;
        logic [31:0]         riff_size;
        logic [31:0]         payload_size;
        logic [OFFSET_W-1:0] payload_offset;
    } wav_out_t;

    function automatic logic [31:0] le32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic [15:0] le16(input logic [31:0] w);
        return {w[7:0], w[15:8]};
    endfunction

endpackage

// ===== rtl/wavhp_core.sv =====
// Per-byte parse step: header state registers and verdict logic.
module wavhp_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  wavhp_pkg::wav_in_t item,
    output logic               emit,
    output wavhp_pkg::wav_out_t result
);

    logic [wavhp_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [31:0]                 win_reg, win_next;
    logic                        ext_reg, ext_next;
    logic [wavhp_pkg::POS_W-1:0] dtp_reg, dtp_next;
    logic                        verdict_reg, verdict_next;
    logic [31:0]                 riff_size_reg, riff_size_next;
    logic [31:0]                 rate_reg, rate_next;
    logic [31:0]                 byte_rate_reg, byte_rate_next;
    logic [31:0]                 psize_reg, psize_next;
    logic [15:0]                 chan_reg, chan_next;
    logic [15:0]                 align_reg, align_next;
    logic [15:0]                 bits_reg, bits_next;

    logic [wavhp_pkg::POS_W-1:0] p;
    logic [wavhp_pkg::POS_W:0]   p_wide;
    logic [wavhp_pkg::POS_W:0]   dtp_tag_end;
    logic [wavhp_pkg::POS_W:0]   dtp_size_end;
    logic [wavhp_pkg::POS_W:0]   ofs_sum;
    logic [31:0]                 w;
    logic                        ext_c;
    logic [wavhp_pkg::POS_W-1:0] dtp_c;
    logic                        active;
    logic                        data_zone;
    logic                        fact_too_long;
    wavhp_pkg::status_t          status;

    always_comb begin
        // Restart values apply on the first byte of a header.
        p      = item.first_byte ? '0 : pos_reg;
        w      = item.first_byte ? {24'd0, item.header_byte}
                                 : {win_reg[23:0], item.header_byte};
        ext_c  = item.first_byte ? 1'b0 : ext_reg;
        dtp_c  = item.first_byte ? wavhp_pkg::POS_W'(wavhp_pkg::DATA_TAG_BASE) : dtp_reg;
        active = step_en && (item.first_byte || !verdict_reg);

        p_wide       = {1'b0, p};
        dtp_tag_end  = {1'b0, dtp_c} + (wavhp_pkg::POS_W+1)'(3);
        dtp_size_end = {1'b0, dtp_c} + (wavhp_pkg::POS_W+1)'(7);
        data_zone    = !ext_c || (p > wavhp_pkg::OFS_FACT_LEN);
        fact_too_long = wavhp_pkg::le32(w) > 32'(wavhp_pkg::FACT_LEN_MAX);

        pos_next       = pos_reg;
        win_next       = win_reg;
        ext_next       = ext_reg;
        dtp_next       = dtp_reg;
        verdict_next   = verdict_reg;
        riff_size_next = riff_size_reg;
        rate_next      = rate_reg;
        byte_rate_next = byte_rate_reg;
        psize_next     = psize_reg;
        chan_next      = chan_reg;
        align_next     = align_reg;
        bits_next      = bits_reg;
        emit           = 1'b0;
        status         = wavhp_pkg::ST_OK;

        if (active) begin
            if (item.first_byte) begin
                riff_size_next = '0;
                rate_next      = '0;
                byte_rate_next = '0;
                psize_next     = '0;
                chan_next      = '0;
                align_next     = '0;
                bits_next      = '0;
            end
            win_next = w;
            ext_next = ext_c;
            dtp_next = dtp_c;
            pos_next = (p < wavhp_pkg::POS_W'(wavhp_pkg::HEADER_BYTES)) ? p + 1'b1 : p;

            // Capture fields as their last byte arrives.
            if (p == wavhp_pkg::OFS_RIFF_SIZE)  riff_size_next = wavhp_pkg::le32(w);
            if (p == wavhp_pkg::OFS_CHANNELS)   chan_next      = wavhp_pkg::le16(w);
            if (p == wavhp_pkg::OFS_RATE)       rate_next      = wavhp_pkg::le32(w);
            if (p == wavhp_pkg::OFS_BYTE_RATE)  byte_rate_next = wavhp_pkg::le32(w);
            if (p == wavhp_pkg::OFS_ALIGN)      align_next     = wavhp_pkg::le16(w);
            if (p == wavhp_pkg::OFS_BITS)       bits_next      = wavhp_pkg::le16(w);
            if (p == wavhp_pkg::OFS_FMT_SIZE)
                ext_next = wavhp_pkg::le32(w) != wavhp_pkg::FMT_PCM_SIZE;
            if (ext_c && p == wavhp_pkg::OFS_FACT_LEN && !fact_too_long)
                dtp_next = wavhp_pkg::POS_W'(wavhp_pkg::DATA_TAG_BASE + wavhp_pkg::FACT_HDR)
                         + wavhp_pkg::POS_W'(wavhp_pkg::le32(w));
            if (data_zone && p_wide == dtp_size_end)
                psize_next = wavhp_pkg::le32(w);

            // Verdict, first failing check wins.
            emit = 1'b1;
            if (p == wavhp_pkg::OFS_RIFF_TAG && w != wavhp_pkg::TAG_RIFF)
                status = wavhp_pkg::ST_NO_RIFF;
            else if (p == wavhp_pkg::OFS_WAVE_TAG && w != wavhp_pkg::TAG_WAVE)
                status = wavhp_pkg::ST_NO_WAVE;
            else if (p == wavhp_pkg::OFS_FMT_TAG && w != wavhp_pkg::TAG_FMT)
                status = wavhp_pkg::ST_NO_FMT;
            else if (p == wavhp_pkg::OFS_FMT_CODE && wavhp_pkg::le16(w) != wavhp_pkg::FMT_TAG_PCM)
                status = wavhp_pkg::ST_NOT_PCM;
            else if (p == wavhp_pkg::OFS_BITS && wavhp_pkg::le16(w) != wavhp_pkg::PCM_BITS)
                status = wavhp_pkg::ST_NOT_16BIT;
            else if (ext_c && p == wavhp_pkg::OFS_EXT_SIZE && w[15:0] != wavhp_pkg::EXT_NONE)
                status = wavhp_pkg::ST_EXT_SET;
            else if (ext_c && p == wavhp_pkg::OFS_FACT_LEN && fact_too_long)
                status = wavhp_pkg::ST_TRUNC;
            else if (data_zone && p_wide == dtp_tag_end && w != wavhp_pkg::TAG_DATA)
                status = wavhp_pkg::ST_NO_DATA;
            else if (data_zone && p_wide == dtp_size_end)
                status = wavhp_pkg::ST_OK;
            else if (item.last_byte)
                status = wavhp_pkg::ST_TRUNC;
            else
                emit = 1'b0;
            verdict_next = emit;
        end
    end

    always_comb begin
        ofs_sum = {1'b0, dtp_c} + (wavhp_pkg::POS_W+1)'(wavhp_pkg::CHUNK_HDR);
        result.status          = status;
        result.num_channels    = chan_next;
        result.samples_per_sec = rate_next;
        result.byte_rate       = byte_rate_next;
        result.block_align     = align_next;
        result.sample_bits     = bits_next;
        result.riff_size       = riff_size_next;
        result.payload_size    = (status == wavhp_pkg::ST_OK) ? psize_next : '0;
        result.payload_offset  = (status == wavhp_pkg::ST_OK)
                               ? wavhp_pkg::OFFSET_W'(ofs_sum) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            win_reg     <= '0;
            ext_reg     <= 1'b0;
            dtp_reg     <= wavhp_pkg::POS_W'(wavhp_pkg::DATA_TAG_BASE);
            verdict_reg <= 1'b1;
        end else begin
            pos_reg     <= pos_next;
            win_reg     <= win_next;
            ext_reg     <= ext_next;
            dtp_reg     <= dtp_next;
            verdict_reg <= verdict_next;
        end
    end

    always_ff @(posedge aclk) begin
        riff_size_reg <= riff_size_next;
        rate_reg      <= rate_next;
        byte_rate_reg <= byte_rate_next;
        psize_reg     <= psize_next;
        chan_reg      <= chan_next;
        align_reg     <= align_next;
        bits_reg      <= bits_next;
    end

endmodule

// ===== rtl/wav_header_parser.sv =====
// Top level of the RIFF/WAVE PCM header parser: input and result registers.
//
// Feed the header one byte per transaction on the s_ channel, in file order.
// Set first_byte on offset 0 of each header to restart parsing, and set
// last_byte on the final byte available. The parser returns exactly one
// verdict transaction per header on the m_ channel: status, the fmt fields
// captured so far, and for a good header the data size and payload offset.
// Bytes that arrive after the verdict, or before any first byte, produce
// nothing.
//
// Each byte accepted into the input register is parsed as it advances, and
// its verdict (if it causes one) is loaded into the result register behind m_valid.
// Throughput is one byte per cycle while no verdict is held back: each byte
// passes once through the parse step between the two registers.
//
// Reset (aresetn low, synchronous) empties both registers and leaves the
// parser idle until a byte with first_byte arrives. When the receiver
// stalls, hold the pending verdict in the result register and the next byte
// in the input register; s_ready drops while both are full and advances
// again in the cycle the verdict is taken.
module wav_header_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wavhp_pkg::wav_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output wavhp_pkg::wav_out_t m_item
);

    logic                in_valid_reg, in_valid_next;
    wavhp_pkg::wav_in_t  in_item_reg;
    logic                out_valid_reg, out_valid_next;
    wavhp_pkg::wav_out_t out_item_reg;
    logic                advance;
    logic                step_emit;
    wavhp_pkg::wav_out_t step_result;

    // Advance the held byte when the result register is free or being drained.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    wavhp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .emit    (step_emit),
        .result  (step_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && step_emit)
            out_valid_next = 1'b1;
        else if (m_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on transaction, hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready)
            in_item_reg <= s_item;
        if (advance && step_emit)
            out_item_reg <= step_result;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    a_stall_means_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without a held result");

    a_ok_offset_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status == wavhp_pkg::ST_OK |->
            m_item.payload_offset >= wavhp_pkg::OFFSET_W'(wavhp_pkg::DATA_TAG_BASE
                                                         + wavhp_pkg::CHUNK_HDR))
        else $error("good verdict with payload offset inside the fmt chunk");

    a_fail_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status != wavhp_pkg::ST_OK |->
            m_item.payload_size == '0 && m_item.payload_offset == '0)
        else $error("failed verdict carries payload information");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.status <= wavhp_pkg::ST_TRUNC)
        else $error("verdict status out of range");

endmodule
